>>> rtl/alarm_clock_controller_macros.svh
// ----------------------------------------------------------------------------
// Alarm clock controller assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef ALARM_CLOCK_CONTROLLER_MACROS_SVH
`define ALARM_CLOCK_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ACC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define ACC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/acc_pkg.sv
// ----------------------------------------------------------------------------
// Alarm clock controller package
// Codes, limits and field layout shared by the controller and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package acc_pkg;

    // Item kind on the input side
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_KEY  = 1'b1;

    // Key codes
    localparam logic [2:0] KEY_UP    = 3'd0;
    localparam logic [2:0] KEY_DOWN  = 3'd1;
    localparam logic [2:0] KEY_LEFT  = 3'd2;
    localparam logic [2:0] KEY_RIGHT = 3'd3;
    localparam logic [2:0] KEY_OK    = 3'd4;
    localparam logic [2:0] KEY_BACK  = 3'd5;

    // Press kinds
    localparam logic [2:0] PRESS_SHORT  = 3'd2;
    localparam logic [2:0] PRESS_LONG   = 3'd3;
    localparam logic [2:0] PRESS_REPEAT = 3'd4;

    // Screens and the extra display code used while ringing
    typedef enum logic [1:0] {
        SCR_CLOCK  = 2'd0,
        SCR_MENU   = 2'd1,
        SCR_PICKER = 2'd2
    } screen_t;

    localparam logic [1:0] DISP_RINGING = 2'd3;

    // Picker fields
    localparam logic [1:0] FLD_HOUR     = 2'd0;
    localparam logic [1:0] FLD_MINUTE   = 2'd1;
    localparam logic [1:0] FLD_MERIDIAN = 2'd2;

    // Limits
    localparam logic [6:0] BRIGHT_MAX   = 7'd100;
    localparam logic [6:0] BRIGHT_STEP  = 7'd5;
    localparam logic [4:0] HOUR_MAX     = 5'd23;
    localparam logic [4:0] HALF_DAY     = 5'd12;
    localparam logic [4:0] HALF_DAY_MAX = 5'd11;
    localparam logic [5:0] MINUTE_MAX   = 6'd59;

    // Reset values
    localparam logic [4:0] ALARM_HOUR_RST = 5'd7;

    // Bus widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    // Result item bit positions
    localparam int OUT_BRIGHT_LSB = 5;
    localparam int OUT_CURSOR_LSB = 25;
    localparam int OUT_EXIT_BIT   = 27;

endpackage

`default_nettype wire

>>> rtl/alarm_clock_controller.sv
// ----------------------------------------------------------------------------
// Alarm clock controller
// Clock face, alarm menu and alarm time picker control with alarm ringing.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while the output side keeps up, and returns
// one result item for each; an accepted item passes through the input
// register and then the result register. All state updates for an item
// happen in the single pass between those two registers, so the next item
// sees them at once. The input side stalls only while the result register is
// still held by the downstream side. The configuration write port is always
// ready; write it only while no item is in flight.
`default_nettype none

module alarm_clock_controller (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration: twelve_hour_mode
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic                            cfg_data,
    // input items
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [4:0] now_hour, [10:5] now_minute, [13:11] key_code,
    // [16:14] press_kind, [23:17] zero
    input  wire logic [acc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] command
    input  wire logic                            s_axis_tuser,
    // result items
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [1:0] display_mode, [2] flash_on, [3] play_melody, [4] colon_on,
    // [11:5] brightness_level, [12] nightlight_on, [13] alarm_armed,
    // [18:14] shown_hour, [24:19] shown_minute, [26:25] cursor,
    // [27] exit_request, [28] save_request, [31:29] zero
    output logic [acc_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    // ------------------------------------------------------------------
    // Handshake control
    // ------------------------------------------------------------------
    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic advance;
    logic s_fire;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Input register (payload, no reset)
    // ------------------------------------------------------------------
    logic       in_command_reg;
    logic [4:0] in_hour_reg;
    logic [5:0] in_minute_reg;
    logic [2:0] in_key_reg;
    logic [2:0] in_kind_reg;

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_command_reg <= s_axis_tuser;
            in_hour_reg    <= s_axis_tdata[4:0];
            in_minute_reg  <= s_axis_tdata[10:5];
            in_key_reg     <= s_axis_tdata[13:11];
            in_kind_reg    <= s_axis_tdata[16:14];
        end
    end

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    logic             twelve_hour_reg;
    acc_pkg::screen_t screen_reg, screen_next;
    logic             ringing_reg, ringing_next;
    logic             flash_reg, flash_next;
    logic             fired_reg, fired_next;
    logic             melody_reg, melody_next;
    logic             colon_reg, colon_next;
    logic [4:0]       cur_hour_reg, cur_hour_next;
    logic [5:0]       cur_minute_reg, cur_minute_next;
    logic             alarm_en_reg, alarm_en_next;
    logic [4:0]       alarm_hour_reg, alarm_hour_next;
    logic [5:0]       alarm_minute_reg, alarm_minute_next;
    logic [4:0]       edit_hour_reg, edit_hour_next;
    logic [5:0]       edit_minute_reg, edit_minute_next;
    logic [1:0]       edit_field_reg, edit_field_next;
    logic             menu_row_reg, menu_row_next;
    logic [6:0]       bright_reg, bright_next;
    logic             night_reg, night_next;

    // Per-item pulses
    logic melody_pulse;
    logic exit_pulse;
    logic save_pulse;

    // ------------------------------------------------------------------
    // Picker arithmetic on the edit hour and minute
    // ------------------------------------------------------------------
    logic       hour_pm;
    logic [4:0] hour_base;
    logic [4:0] base_up;
    logic [4:0] base_dn;
    logic [4:0] hour12_up;
    logic [4:0] hour12_dn;
    logic [4:0] hour24_up;
    logic [4:0] hour24_dn;
    logic [4:0] hour_flip;
    logic [5:0] minute_up;
    logic [5:0] minute_dn;
    logic [1:0] last_field;

    always_comb
    begin
        hour_pm   = (edit_hour_reg >= acc_pkg::HALF_DAY);
        hour_base = hour_pm ? (edit_hour_reg - acc_pkg::HALF_DAY) : edit_hour_reg;
        base_up   = (hour_base == acc_pkg::HALF_DAY_MAX) ? 5'd0 : (hour_base + 5'd1);
        base_dn   = (hour_base == 5'd0) ? acc_pkg::HALF_DAY_MAX : (hour_base - 5'd1);
        hour12_up = hour_pm ? (base_up + acc_pkg::HALF_DAY) : base_up;
        hour12_dn = hour_pm ? (base_dn + acc_pkg::HALF_DAY) : base_dn;
        hour24_up = (edit_hour_reg == acc_pkg::HOUR_MAX) ? 5'd0 : (edit_hour_reg + 5'd1);
        hour24_dn = (edit_hour_reg == 5'd0) ? acc_pkg::HOUR_MAX : (edit_hour_reg - 5'd1);
        // meridian flip keeps the 12-hour value
        hour_flip = hour_pm ? hour_base : (hour_base + acc_pkg::HALF_DAY);
        minute_up = (edit_minute_reg == acc_pkg::MINUTE_MAX) ? 6'd0
                                                             : (edit_minute_reg + 6'd1);
        minute_dn = (edit_minute_reg == 6'd0) ? acc_pkg::MINUTE_MAX
                                              : (edit_minute_reg - 6'd1);
        last_field = twelve_hour_reg ? acc_pkg::FLD_MERIDIAN : acc_pkg::FLD_MINUTE;
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    logic tick_match;
    logic picker_step;
    logic up_down;

    assign tick_match = (in_hour_reg == alarm_hour_reg) && (in_minute_reg == alarm_minute_reg);
    assign up_down    = (in_key_reg == acc_pkg::KEY_UP) || (in_key_reg == acc_pkg::KEY_DOWN);
    assign picker_step = (screen_reg == acc_pkg::SCR_PICKER)
                         && ((in_kind_reg == acc_pkg::PRESS_SHORT)
                             || ((in_kind_reg == acc_pkg::PRESS_REPEAT) && up_down));

    always_comb
    begin
        screen_next       = screen_reg;
        ringing_next      = ringing_reg;
        flash_next        = flash_reg;
        fired_next        = fired_reg;
        melody_next       = melody_reg;
        colon_next        = colon_reg;
        cur_hour_next     = cur_hour_reg;
        cur_minute_next   = cur_minute_reg;
        alarm_en_next     = alarm_en_reg;
        alarm_hour_next   = alarm_hour_reg;
        alarm_minute_next = alarm_minute_reg;
        edit_hour_next    = edit_hour_reg;
        edit_minute_next  = edit_minute_reg;
        edit_field_next   = edit_field_reg;
        menu_row_next     = menu_row_reg;
        bright_next       = bright_reg;
        night_next        = night_reg;
        melody_pulse      = 1'b0;
        exit_pulse        = 1'b0;
        save_pulse        = 1'b0;

        if (advance)
        begin
            if (in_command_reg == acc_pkg::CMD_TICK)
            begin
                // latch time, toggle colon, check alarm
                cur_hour_next   = in_hour_reg;
                cur_minute_next = in_minute_reg;
                colon_next      = !colon_reg;
                if (!alarm_en_reg || !tick_match)
                begin
                    fired_next = 1'b0;
                end
                else if (!fired_reg && !ringing_reg)
                begin
                    ringing_next = 1'b1;
                    fired_next   = 1'b1;
                    flash_next   = 1'b1;
                    melody_next  = 1'b0;
                end
                if (ringing_next)
                begin
                    flash_next   = !flash_next;
                    melody_pulse = !melody_next;
                    melody_next  = !melody_next;
                end
            end
            else if (ringing_reg)
            begin
                // any short or long press silences
                if ((in_kind_reg == acc_pkg::PRESS_SHORT) ||
                    (in_kind_reg == acc_pkg::PRESS_LONG))
                begin
                    ringing_next = 1'b0;
                end
            end
            else if (picker_step)
            begin
                case (in_key_reg)
                    acc_pkg::KEY_UP,
                    acc_pkg::KEY_DOWN:
                    begin
                        case (edit_field_reg)
                            acc_pkg::FLD_HOUR:
                            begin
                                if (twelve_hour_reg)
                                begin
                                    edit_hour_next = (in_key_reg == acc_pkg::KEY_UP)
                                                     ? hour12_up : hour12_dn;
                                end
                                else
                                begin
                                    edit_hour_next = (in_key_reg == acc_pkg::KEY_UP)
                                                     ? hour24_up : hour24_dn;
                                end
                            end
                            acc_pkg::FLD_MINUTE:
                            begin
                                edit_minute_next = (in_key_reg == acc_pkg::KEY_UP)
                                                   ? minute_up : minute_dn;
                            end
                            default:
                            begin
                                edit_hour_next = hour_flip;
                            end
                        endcase
                    end
                    acc_pkg::KEY_LEFT:
                    begin
                        if (edit_field_reg != acc_pkg::FLD_HOUR)
                        begin
                            edit_field_next = edit_field_reg - 2'd1;
                        end
                    end
                    acc_pkg::KEY_RIGHT:
                    begin
                        if (edit_field_reg < last_field)
                        begin
                            edit_field_next = edit_field_reg + 2'd1;
                        end
                    end
                    acc_pkg::KEY_OK,
                    acc_pkg::KEY_BACK:
                    begin
                        alarm_hour_next   = edit_hour_reg;
                        alarm_minute_next = edit_minute_reg;
                        save_pulse        = 1'b1;
                        screen_next       = acc_pkg::SCR_MENU;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (in_kind_reg == acc_pkg::PRESS_SHORT)
            begin
                if (screen_reg == acc_pkg::SCR_MENU)
                begin
                    // alarm menu
                    case (in_key_reg)
                        acc_pkg::KEY_UP,
                        acc_pkg::KEY_DOWN:
                        begin
                            menu_row_next = !menu_row_reg;
                        end
                        acc_pkg::KEY_LEFT,
                        acc_pkg::KEY_RIGHT:
                        begin
                            if (!menu_row_reg)
                            begin
                                alarm_en_next = !alarm_en_reg;
                                save_pulse    = 1'b1;
                            end
                        end
                        acc_pkg::KEY_OK:
                        begin
                            if (!menu_row_reg)
                            begin
                                alarm_en_next = !alarm_en_reg;
                                save_pulse    = 1'b1;
                            end
                            else
                            begin
                                edit_hour_next   = alarm_hour_reg;
                                edit_minute_next = alarm_minute_reg;
                                edit_field_next  = acc_pkg::FLD_HOUR;
                                screen_next      = acc_pkg::SCR_PICKER;
                            end
                        end
                        acc_pkg::KEY_BACK:
                        begin
                            screen_next = acc_pkg::SCR_CLOCK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    // clock screen
                    case (in_key_reg)
                        acc_pkg::KEY_BACK:
                        begin
                            exit_pulse = 1'b1;
                        end
                        acc_pkg::KEY_UP:
                        begin
                            if (bright_reg < acc_pkg::BRIGHT_MAX)
                            begin
                                night_next = 1'b0;
                                if (bright_reg > (acc_pkg::BRIGHT_MAX - acc_pkg::BRIGHT_STEP))
                                begin
                                    bright_next = acc_pkg::BRIGHT_MAX;
                                end
                                else
                                begin
                                    bright_next = bright_reg + acc_pkg::BRIGHT_STEP;
                                end
                            end
                        end
                        acc_pkg::KEY_DOWN:
                        begin
                            if (bright_reg == 7'd0)
                            begin
                                night_next = !night_reg;
                            end
                            else if (bright_reg > acc_pkg::BRIGHT_STEP)
                            begin
                                bright_next = bright_reg - acc_pkg::BRIGHT_STEP;
                            end
                            else
                            begin
                                bright_next = 7'd0;
                                night_next  = 1'b1;
                            end
                        end
                        acc_pkg::KEY_RIGHT:
                        begin
                            menu_row_next = 1'b0;
                            screen_next   = acc_pkg::SCR_MENU;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result fields from the updated state
    // ------------------------------------------------------------------
    logic [1:0] res_mode;
    logic       res_flash;
    logic [4:0] res_hour;
    logic [5:0] res_minute;
    logic [1:0] res_cursor;
    logic [acc_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    always_comb
    begin
        res_mode   = ringing_next ? acc_pkg::DISP_RINGING : screen_next;
        res_flash  = ringing_next && flash_next;
        res_hour   = cur_hour_next;
        res_minute = cur_minute_next;
        res_cursor = 2'd0;
        if (!ringing_next)
        begin
            case (screen_next)
                acc_pkg::SCR_MENU:
                begin
                    res_hour   = alarm_hour_next;
                    res_minute = alarm_minute_next;
                    res_cursor = {1'b0, menu_row_next};
                end
                acc_pkg::SCR_PICKER:
                begin
                    res_hour   = edit_hour_next;
                    res_minute = edit_minute_next;
                    res_cursor = edit_field_next;
                end
                default:
                begin
                end
            endcase
        end
        out_data_next = {3'b000, save_pulse, exit_pulse, res_cursor, res_minute, res_hour,
                         alarm_en_next, night_next, bright_next, colon_next,
                         melody_pulse, res_flash, res_mode};
    end

    // ------------------------------------------------------------------
    // Result register (payload, no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            twelve_hour_reg  <= 1'b0;
            screen_reg       <= acc_pkg::SCR_CLOCK;
            ringing_reg      <= 1'b0;
            flash_reg        <= 1'b0;
            fired_reg        <= 1'b0;
            melody_reg       <= 1'b0;
            colon_reg        <= 1'b1;
            cur_hour_reg     <= 5'd0;
            cur_minute_reg   <= 6'd0;
            alarm_en_reg     <= 1'b0;
            alarm_hour_reg   <= acc_pkg::ALARM_HOUR_RST;
            alarm_minute_reg <= 6'd0;
            edit_hour_reg    <= 5'd0;
            edit_minute_reg  <= 6'd0;
            edit_field_reg   <= acc_pkg::FLD_HOUR;
            menu_row_reg     <= 1'b0;
            bright_reg       <= acc_pkg::BRIGHT_MAX;
            night_reg        <= 1'b0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                twelve_hour_reg <= cfg_data;
            end
            screen_reg       <= screen_next;
            ringing_reg      <= ringing_next;
            flash_reg        <= flash_next;
            fired_reg        <= fired_next;
            melody_reg       <= melody_next;
            colon_reg        <= colon_next;
            cur_hour_reg     <= cur_hour_next;
            cur_minute_reg   <= cur_minute_next;
            alarm_en_reg     <= alarm_en_next;
            alarm_hour_reg   <= alarm_hour_next;
            alarm_minute_reg <= alarm_minute_next;
            edit_hour_reg    <= edit_hour_next;
            edit_minute_reg  <= edit_minute_next;
            edit_field_reg   <= edit_field_next;
            menu_row_reg     <= menu_row_next;
            bright_reg       <= bright_next;
            night_reg        <= night_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/acc_checker.sv
// ----------------------------------------------------------------------------
// Alarm clock controller port checker
// Port-level checks on result items, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "alarm_clock_controller_macros.svh"

module acc_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [acc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    // Decoded result fields
    logic [1:0] chk_mode;
    logic       chk_flash;
    logic [6:0] chk_bright;
    logic [1:0] chk_cursor;
    logic       chk_exit;
    logic       flash_face_ok;
    logic       out_stall;

    assign chk_mode   = m_axis_tdata[1:0];
    assign chk_flash  = m_axis_tdata[2];
    assign chk_bright = m_axis_tdata[acc_pkg::OUT_BRIGHT_LSB +: 7];
    assign chk_cursor = m_axis_tdata[acc_pkg::OUT_CURSOR_LSB +: 2];
    assign chk_exit   = m_axis_tdata[acc_pkg::OUT_EXIT_BIT];

    assign flash_face_ok = (chk_mode == acc_pkg::DISP_RINGING) && (chk_cursor == 2'd0);
    assign out_stall     = m_axis_tvalid && !m_axis_tready;

    // Brightness stays within percent range
    `ACC_ASSERT_IMP(a_bright_range, clk, rst_n, m_axis_tvalid, chk_bright <= acc_pkg::BRIGHT_MAX)

    // Flash is only shown while ringing, and then with no cursor
    `ACC_ASSERT_IMP(a_flash_ring, clk, rst_n, m_axis_tvalid && chk_flash, flash_face_ok)

    // Exit is only requested from the clock screen
    `ACC_ASSERT_IMP(a_exit_clock, clk, rst_n, m_axis_tvalid && chk_exit, chk_mode == acc_pkg::SCR_CLOCK)

    // A stalled result item holds
    `ACC_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind alarm_clock_controller acc_checker u_acc_checker (.*);

`default_nettype wire
